@@ rtl/csort_pkg.sv @@
// ----------------------------------------------------------------------------
// csort_pkg
// Shared types, codes and helpers of the collation-ranked string sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package csort_pkg;

    localparam int IDX_W  = 6;
    localparam int RANK_W = 10;
    localparam int APOS_W = 9;

    typedef enum logic [1:0] {
        KIND_ALPHA = 2'd0,
        KIND_TEXT  = 2'd1,
        KIND_SORT  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_OUTER,
        ST_ORD_RD,
        ST_ORD_WAIT,
        ST_CMP_RD,
        ST_CMP_BYTE,
        ST_CMP_RANK,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_HOLD
    } state_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Map upper-case ASCII letters onto lower case so both share one entry
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/csort_rank_mem.sv @@
// ----------------------------------------------------------------------------
// csort_rank_mem
// Rank table: 256-entry memory with per-entry valid bits, two read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module csort_rank_mem (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  clr,
    input  wire logic                                  wr_en,
    input  wire logic [7:0]                            wr_byte,
    input  wire logic [csort_pkg::APOS_W-1:0]          wr_rank,
    input  wire logic [7:0]                            rd_byte_a,
    input  wire logic [7:0]                            rd_byte_b,
    output logic signed [csort_pkg::RANK_W-1:0]        rank_a,
    output logic signed [csort_pkg::RANK_W-1:0]        rank_b
);

    logic [csort_pkg::APOS_W-1:0] mem [0:255];
    logic [255:0]                 vld_reg, vld_next;
    logic [csort_pkg::APOS_W-1:0] da_reg, db_reg;
    logic                         va_reg, vb_reg;
    logic [7:0]                   ba_reg, bb_reg;
    logic [7:0]                   wa, ra, rb;

    assign wa = csort_pkg::fold_case(wr_byte);
    assign ra = csort_pkg::fold_case(rd_byte_a);
    assign rb = csort_pkg::fold_case(rd_byte_b);

    // Clear valid bits on alphabet restart, then mark the written entry
    always_comb begin
        vld_next = clr ? '0 : vld_reg;
        if (wr_en) begin
            vld_next[wa] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Write and registered reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wa] <= wr_rank;
        end
        da_reg <= mem[ra];
        db_reg <= mem[rb];
        va_reg <= vld_reg[ra] && !(clr || (wr_en && wa == ra));
        vb_reg <= vld_reg[rb] && !(clr || (wr_en && wa == rb));
        ba_reg <= rd_byte_a;
        bb_reg <= rd_byte_b;
    end

    // Separators always rank minus one; unwritten entries rank zero
    always_comb begin
        if (ba_reg == csort_pkg::CH_NUL || ba_reg == csort_pkg::CH_LF ||
            ba_reg == csort_pkg::CH_SPACE) begin
            rank_a = '1;
        end else if (va_reg) begin
            rank_a = {1'b0, da_reg};
        end else begin
            rank_a = '0;
        end
        if (bb_reg == csort_pkg::CH_NUL || bb_reg == csort_pkg::CH_LF ||
            bb_reg == csort_pkg::CH_SPACE) begin
            rank_b = '1;
        end else if (vb_reg) begin
            rank_b = {1'b0, db_reg};
        end else begin
            rank_b = '0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/csort_text_mem.sv @@
// ----------------------------------------------------------------------------
// csort_text_mem
// String byte store and string length table, one write and two read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module csort_text_mem #(
    parameter int MAX_STRINGS = 64,
    parameter int MAX_LENGTH  = 256,
    parameter int IW          = 6,
    parameter int LW          = 9
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_idx,
    input  wire logic [LW-1:0] wr_pos,
    input  wire logic [7:0]    wr_byte,
    input  wire logic [IW-1:0] rd_idx_a,
    input  wire logic [IW-1:0] rd_idx_b,
    input  wire logic [LW-1:0] rd_pos,
    output logic [7:0]         byte_a,
    output logic [7:0]         byte_b
);

    localparam int DEPTH = MAX_STRINGS * MAX_LENGTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LEN_C = AW'(MAX_LENGTH);

    logic [7:0]    store [0:DEPTH-1];
    logic [LW-1:0] lens  [0:MAX_STRINGS-1];
    logic [7:0]    da_reg, db_reg;
    logic [LW-1:0] la_reg, lb_reg;
    logic [LW-1:0] pos_reg;
    logic [AW-1:0] wa, ra, rb;

    assign wa = AW'(wr_idx) * LEN_C + AW'(wr_pos);
    assign ra = AW'(rd_idx_a) * LEN_C + AW'(rd_pos);
    assign rb = AW'(rd_idx_b) * LEN_C + AW'(rd_pos);

    // Append byte and bump length
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wa]    <= wr_byte;
            lens[wr_idx] <= wr_pos + LW'(1);
        end
        da_reg  <= store[ra];
        db_reg  <= store[rb];
        la_reg  <= lens[rd_idx_a];
        lb_reg  <= lens[rd_idx_b];
        pos_reg <= rd_pos;
    end

    // Positions at or past the length read as NUL
    assign byte_a = (pos_reg < la_reg) ? da_reg : csort_pkg::CH_NUL;
    assign byte_b = (pos_reg < lb_reg) ? db_reg : csort_pkg::CH_NUL;

endmodule

`default_nettype wire

@@ rtl/collation_ranked_string_sorter_unit.sv @@
// ----------------------------------------------------------------------------
// collation_ranked_string_sorter_unit
// Loads an alphabet and strings byte by byte and emits a stable sorted order.
// ----------------------------------------------------------------------------
// Alphabet and string bytes are taken one per cycle. A sort request runs an
// insertion sort held in an order memory; each string comparison walks byte
// positions through the string and rank memories (ST_CMP_RD, ST_CMP_BYTE,
// ST_CMP_RANK), up to MAX_LENGTH positions, stopping at the first differing
// rank. Each insertion step reads the order memory in ST_ORD_RD/ST_ORD_WAIT.
// Results are read out one index at a time and held in ST_EMIT_HOLD until
// taken. No item is accepted while a sort or its output run is in progress.
`default_nettype none

module collation_ranked_string_sorter_unit #(
    parameter int MAX_STRINGS    = 64,
    parameter int MAX_LENGTH     = 256,
    parameter int ALPHABET_SLOTS = 300
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // symbol[7:0], first[8], new_set[9]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // string_index[5:0]
    output logic             m_tlast
);

    localparam int IW = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
    localparam int CW = $clog2(MAX_STRINGS + 1);
    localparam int LW = $clog2(MAX_LENGTH + 1);
    localparam logic [CW-1:0] MAXS_C = CW'(MAX_STRINGS);
    localparam logic [LW-1:0] MAXL_C = LW'(MAX_LENGTH);
    localparam logic [LW-1:0] LASTP_C = LW'(MAX_LENGTH - 1);
    localparam logic [csort_pkg::APOS_W-1:0] SLOTS_C =
        csort_pkg::APOS_W'(ALPHABET_SLOTS);

    csort_pkg::state_t state_reg, state_next;
    csort_pkg::kind_t  kind;

    logic [7:0] sym;
    logic       first, new_set, acc;

    logic [csort_pkg::APOS_W-1:0] apos_reg, apos_next;
    logic [CW-1:0] count_reg, count_next;
    logic          open_reg, open_next;
    logic [LW-1:0] clen_reg, clen_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IW-1:0] key_reg, key_next, x_reg, x_next;
    logic [LW-1:0] p_reg, p_next;
    logic          mv_reg, mv_next, ml_reg, ml_next;
    logic [IW-1:0] md_reg, md_next;

    // Load path signals
    logic          r_clr, r_wr;
    logic signed [csort_pkg::RANK_W-1:0] rank_a, rank_b;
    logic          t_wr;
    logic [IW-1:0] t_idx;
    logic [7:0]    t_byte_a, t_byte_b;
    logic [CW-1:0] eff_cnt;
    logic          eff_open;
    logic [LW-1:0] eff_len;

    // Order memory
    logic [IW-1:0] order_mem [0:MAX_STRINGS-1];
    logic          o_wr;
    logic [CW-1:0] o_waddr, o_raddr;
    logic [IW-1:0] o_wdata, o_rdata_reg;

    assign sym     = s_tdata[7:0];
    assign first   = s_tdata[8];
    assign new_set = s_tdata[9];
    assign kind    = csort_pkg::kind_t'(s_tuser);
    assign acc     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (o_wr) begin
            order_mem[o_waddr[IW-1:0]] <= o_wdata;
        end
        o_rdata_reg <= order_mem[o_raddr[IW-1:0]];
    end

    csort_rank_mem u_rank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr       (r_clr),
        .wr_en     (r_wr),
        .wr_byte   (sym),
        .wr_rank   (apos_next),
        .rd_byte_a (t_byte_a),
        .rd_byte_b (t_byte_b),
        .rank_a    (rank_a),
        .rank_b    (rank_b)
    );

    csort_text_mem #(
        .MAX_STRINGS (MAX_STRINGS),
        .MAX_LENGTH  (MAX_LENGTH),
        .IW          (IW),
        .LW          (LW)
    ) u_text (
        .aclk     (aclk),
        .wr_en    (t_wr),
        .wr_idx   (t_idx),
        .wr_pos   (eff_len),
        .wr_byte  (sym),
        .rd_idx_a (x_reg),
        .rd_idx_b (key_reg),
        .rd_pos   (p_reg),
        .byte_a   (t_byte_a),
        .byte_b   (t_byte_b)
    );

    // Load decode for an accepted transaction
    always_comb begin
        r_clr     = 1'b0;
        r_wr      = 1'b0;
        t_wr      = 1'b0;
        apos_next = apos_reg;
        eff_cnt   = count_reg;
        eff_open  = open_reg;
        eff_len   = clen_reg;
        t_idx     = '0;
        if (acc && kind == csort_pkg::KIND_ALPHA) begin
            if (first) begin
                r_clr     = 1'b1;
                apos_next = '0;
            end
            if (apos_next < SLOTS_C) begin
                r_wr      = 1'b1;
                apos_next = apos_next + 1'b1;
            end
        end
        if (acc && kind == csort_pkg::KIND_TEXT) begin
            if (first) begin
                if (new_set) begin
                    eff_cnt = '0;
                end
                if (eff_cnt < MAXS_C) begin
                    eff_cnt  = eff_cnt + 1'b1;
                    eff_open = 1'b1;
                    eff_len  = '0;
                end else begin
                    eff_open = 1'b0;
                end
            end
            if (eff_open && eff_cnt != '0 && eff_len < MAXL_C) begin
                t_wr  = 1'b1;
                t_idx = IW'(eff_cnt - 1'b1);
            end
        end
    end

    // Next state and sort sequencing
    always_comb begin
        state_next = state_reg;
        count_next = eff_cnt;
        open_next  = eff_open;
        clen_next  = t_wr ? eff_len + 1'b1 : eff_len;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        key_next   = key_reg;
        x_next     = x_reg;
        p_next     = p_reg;
        mv_next    = mv_reg;
        ml_next    = ml_reg;
        md_next    = md_reg;
        o_wr       = 1'b0;
        o_waddr    = '0;
        o_wdata    = '0;
        o_raddr    = '0;
        case (state_reg)
            csort_pkg::ST_IDLE: begin
                if (acc && kind == csort_pkg::KIND_SORT && count_reg != '0) begin
                    state_next = csort_pkg::ST_INIT;
                end
            end
            csort_pkg::ST_INIT: begin
                o_wr    = 1'b1;
                o_waddr = '0;
                o_wdata = '0;
                i_next  = CW'(1);
                state_next = (count_reg == CW'(1)) ? csort_pkg::ST_EMIT_RD
                                                   : csort_pkg::ST_OUTER;
                k_next  = '0;
            end
            csort_pkg::ST_OUTER: begin
                key_next   = IW'(i_reg);
                j_next     = i_reg;
                state_next = csort_pkg::ST_ORD_RD;
            end
            csort_pkg::ST_ORD_RD: begin
                o_raddr    = j_reg - 1'b1;
                state_next = csort_pkg::ST_ORD_WAIT;
            end
            csort_pkg::ST_ORD_WAIT: begin
                x_next     = o_rdata_reg;
                p_next     = '0;
                state_next = csort_pkg::ST_CMP_RD;
            end
            csort_pkg::ST_CMP_RD: begin
                state_next = csort_pkg::ST_CMP_BYTE;
            end
            csort_pkg::ST_CMP_BYTE: begin
                state_next = csort_pkg::ST_CMP_RANK;
            end
            csort_pkg::ST_CMP_RANK: begin
                if (rank_a > rank_b) begin
                    // Shift the larger string up one slot
                    o_wr    = 1'b1;
                    o_waddr = j_reg;
                    o_wdata = x_reg;
                    j_next  = j_reg - 1'b1;
                    state_next = (j_reg == CW'(1)) ? csort_pkg::ST_PLACE
                                                   : csort_pkg::ST_ORD_RD;
                end else if (rank_a < rank_b || p_reg == LASTP_C) begin
                    o_wr    = 1'b1;
                    o_waddr = j_reg;
                    o_wdata = key_reg;
                    i_next  = i_reg + 1'b1;
                    state_next = (i_reg + 1'b1 == count_reg) ? csort_pkg::ST_EMIT_RD
                                                            : csort_pkg::ST_OUTER;
                end else begin
                    p_next     = p_reg + 1'b1;
                    state_next = csort_pkg::ST_CMP_RD;
                end
            end
            csort_pkg::ST_PLACE: begin
                o_wr    = 1'b1;
                o_waddr = j_reg;
                o_wdata = key_reg;
                i_next  = i_reg + 1'b1;
                state_next = (i_reg + 1'b1 == count_reg) ? csort_pkg::ST_EMIT_RD
                                                        : csort_pkg::ST_OUTER;
            end
            csort_pkg::ST_EMIT_RD: begin
                o_raddr    = k_reg;
                state_next = csort_pkg::ST_EMIT_LD;
            end
            csort_pkg::ST_EMIT_LD: begin
                mv_next    = 1'b1;
                md_next    = o_rdata_reg;
                ml_next    = (k_reg + 1'b1 == count_reg);
                state_next = csort_pkg::ST_EMIT_HOLD;
            end
            csort_pkg::ST_EMIT_HOLD: begin
                if (m_tready) begin
                    mv_next    = 1'b0;
                    k_next     = k_reg + 1'b1;
                    state_next = ml_reg ? csort_pkg::ST_IDLE : csort_pkg::ST_EMIT_RD;
                end
            end
            default: begin
                state_next = csort_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_tready = (state_reg == csort_pkg::ST_IDLE);
        m_tvalid = mv_reg;
        m_tdata  = 8'(md_reg);
        m_tlast  = ml_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csort_pkg::ST_IDLE;
            apos_reg  <= '0;
            count_reg <= '0;
            open_reg  <= 1'b0;
            clen_reg  <= '0;
            mv_reg    <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            p_reg     <= '0;
        end else begin
            state_reg <= state_next;
            apos_reg  <= apos_next;
            count_reg <= count_next;
            open_reg  <= open_next;
            clen_reg  <= clen_next;
            mv_reg    <= mv_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            p_reg     <= p_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        x_reg   <= x_next;
        md_reg  <= md_next;
        ml_reg  <= ml_next;
    end

endmodule

`default_nettype wire
